// ----- src/hst_pkg.sv -----
// ----------------------------------------------------------------------------
// hst_pkg
// shared types and constants of the hashed slot table
// ----------------------------------------------------------------------------
package hst_pkg;

	localparam logic [2:0] CMD_WRITE   = 3'd0;
	localparam logic [2:0] CMD_READ    = 3'd1;
	localparam logic [2:0] CMD_DELETE  = 3'd2;
	localparam logic [2:0] CMD_CLEANUP = 3'd3;
	localparam logic [2:0] CMD_CLEAR   = 3'd4;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_LARGE = 2'd1;
	localparam logic [1:0] ST_MISS  = 2'd2;

	localparam logic [13:0] ENTRY_OVERHEAD = 14'd12;
	localparam logic [31:0] CRC_POLY       = 32'hEDB88320;

	// one classified item as queued between front and back
	typedef struct packed {
		logic [2:0]  command;
		logic [63:0] key;
		logic [3:0]  key_bytes;
		logic [63:0] value;
		logic [3:0]  value_bytes;
		logic [63:0] expiry_time;
		logic [63:0] current_time;
		logic        too_large;
		logic [31:0] crc;
	} job_t;

	// one crc step over a key byte
	function automatic logic [31:0] crc_byte(input logic [31:0] c_in,
		input logic [7:0] b);
		logic [31:0] c;
		c = c_in ^ {24'd0, b};
		for (int k = 0; k < 8; k++)
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		return c;
	endfunction

	function automatic logic [63:0] byte_mask(input logic [3:0] n);
		logic [63:0] m;
		m = '0;
		for (int k = 0; k < 8; k++)
			if (k < int'(n))
				m[k*8 +: 8] = 8'hFF;
		return m;
	endfunction

endpackage

// ----- src/hst_ram.sv -----
// ----------------------------------------------------------------------------
// hst_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
module hst_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// registered read, old data returned on a write
	always_ff @(posedge clk) begin
		if (we)
			mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule

// ----- src/hst_front.sv -----
// ----------------------------------------------------------------------------
// hst_front
// accepts items, clamps lengths, masks key and value, checks size and hashes the key bytewise
// ----------------------------------------------------------------------------
module hst_front #(
	parameter int KEY_BYTES_MAX   = 8,
	parameter int VALUE_BYTES_MAX = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [2:0]   command,
	input  logic [63:0]  key,
	input  logic [3:0]   key_bytes,
	input  logic [63:0]  value,
	input  logic [3:0]   value_bytes,
	input  logic [63:0]  expiry_time,
	input  logic [63:0]  current_time,
	input  logic [12:0]  slot_bytes,
	output logic         job_valid,
	input  logic         job_ready,
	output hst_pkg::job_t job
);
	import hst_pkg::*;

	localparam logic [3:0] KMAX = 4'(KEY_BYTES_MAX);
	localparam logic [3:0] VMAX = 4'(VALUE_BYTES_MAX);

	logic       busy_q;
	logic [3:0] idx_q;
	job_t       job_q;
	logic [3:0] klen, vlen;

	assign klen = (key_bytes > KMAX) ? KMAX : key_bytes;
	assign vlen = (value_bytes > VMAX) ? VMAX : value_bytes;

	assign in_ready  = !busy_q && !job_valid;
	assign job       = job_q;

	// hash one key byte per cycle, then hand over
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			job_valid <= 1'b0;
			idx_q     <= '0;
		end else begin
			if (job_valid && job_ready)
				job_valid <= 1'b0;
			if (in_valid && in_ready) begin
				busy_q  <= 1'b1;
				idx_q   <= '0;
			end else if (busy_q) begin
				if (idx_q == job_q.key_bytes) begin
					busy_q    <= 1'b0;
					job_valid <= 1'b1;
				end else begin
					idx_q <= idx_q + 4'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			job_q.command      <= command;
			job_q.key          <= key & byte_mask(klen);
			job_q.key_bytes    <= klen;
			job_q.value        <= value & byte_mask(vlen);
			job_q.value_bytes  <= vlen;
			job_q.expiry_time  <= expiry_time;
			job_q.current_time <= current_time;
			job_q.too_large    <= ({10'd0, klen} + {10'd0, vlen} + ENTRY_OVERHEAD)
				> {1'b0, slot_bytes};
			job_q.crc          <= 32'hFFFFFFFF;
		end else if (busy_q) begin
			if (idx_q == job_q.key_bytes)
				job_q.crc <= ~job_q.crc;
			else
				job_q.crc <= crc_byte(job_q.crc, job_q.key[idx_q[2:0]*8 +: 8]);
		end
	end
endmodule

// ----- src/hst_back.sv -----
// ----------------------------------------------------------------------------
// hst_back
// probes and updates the slot memories, produces one result per job
// ----------------------------------------------------------------------------
module hst_back #(
	parameter int SLOT_DEPTH = 256
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          job_valid,
	output logic          job_ready,
	input  hst_pkg::job_t job,
	input  logic [8:0]    slot_count,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [1:0]    status,
	output logic          hit,
	output logic [63:0]   read_value,
	output logic [3:0]    read_value_bytes,
	output logic [8:0]    removed_count
);
	import hst_pkg::*;

	localparam int AW = $clog2(SLOT_DEPTH);
	localparam int CW = AW + 1;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MOD  = 3'd1;
	localparam logic [2:0] S_RD   = 3'd2;
	localparam logic [2:0] S_CHK  = 3'd3;
	localparam logic [2:0] S_OUT  = 3'd4;
	localparam logic [2:0] S_FIN  = 3'd5;

	logic [2:0]    state_q;
	job_t          job_q;
	logic [CW-1:0] count_q;
	logic [31:0]   rem_q;
	logic [5:0]    mbit_q;
	logic [AW-1:0] idx_q, start_q;
	logic [CW-1:0] visited_q;
	logic [8:0]    removed_q;
	logic [SLOT_DEPTH-1:0] used_q;

	// memories
	logic          we;
	logic [AW-1:0] addr;
	logic [3:0]    kl_r, vl_r;
	logic [63:0]   ex_r, key_r, val_r;

	hst_ram #(.WIDTH(4),  .DEPTH(SLOT_DEPTH)) u_kl (.clk, .we, .addr,
		.wdata(job_q.key_bytes), .rdata(kl_r));
	hst_ram #(.WIDTH(4),  .DEPTH(SLOT_DEPTH)) u_vl (.clk, .we, .addr,
		.wdata(job_q.value_bytes), .rdata(vl_r));
	hst_ram #(.WIDTH(64), .DEPTH(SLOT_DEPTH)) u_ex (.clk, .we, .addr,
		.wdata(job_q.expiry_time), .rdata(ex_r));
	hst_ram #(.WIDTH(64), .DEPTH(SLOT_DEPTH)) u_key (.clk, .we, .addr,
		.wdata(job_q.key), .rdata(key_r));
	hst_ram #(.WIDTH(64), .DEPTH(SLOT_DEPTH)) u_val (.clk, .we, .addr,
		.wdata(job_q.value), .rdata(val_r));

	// effective slot count, clamped
	logic [CW-1:0] count_eff;
	always_comb begin
		if (slot_count == 9'd0)
			count_eff = CW'(1);
		else if ({23'd0, slot_count} > SLOT_DEPTH)
			count_eff = CW'(SLOT_DEPTH);
		else
			count_eff = CW'(slot_count);
	end

	// slot occupied when its occupancy flop is set and its key length nonzero; occupancy kept in flops
	logic       occ, is_match, is_write, is_sweep, expired;
	logic [AW-1:0] idx_next;
	assign occ      = used_q[idx_q] && kl_r != 4'd0;
	assign is_match = occ && kl_r == job_q.key_bytes && key_r == job_q.key;
	assign is_write = job_q.command == CMD_WRITE;
	assign is_sweep = job_q.command == CMD_CLEANUP || job_q.command == CMD_CLEAR;
	assign expired  = occ && ex_r != 64'd0 && ex_r <= job_q.current_time;
	assign idx_next = ({1'b0, idx_q} + CW'(1) == count_q) ? '0 : AW'(idx_q + 1'b1);

	assign addr      = idx_q;
	assign we        = state_q == S_CHK && is_write && !(occ && !is_match) &&
		job_q.key_bytes != 4'd0;
	assign job_ready = state_q == S_IDLE;

	// 32-step restoring remainder of crc by slot count, one bit per cycle
	logic [32:0] rem_sh;
	assign rem_sh = {rem_q, job_q.crc[mbit_q[4:0]]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_valid <= 1'b0;
			used_q    <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (job_valid) begin
						state_q <= S_MOD;
					end
				end
				S_MOD: begin
					if (job_q.command > CMD_CLEAR || (is_write && job_q.too_large))
						state_q <= S_OUT;
					else if (is_sweep)
						state_q <= S_RD;
					else if (mbit_q == 6'd0)
						state_q <= S_RD;
				end
				S_RD: state_q <= S_CHK;
				S_CHK: begin
					if (is_sweep) begin
						if (job_q.command == CMD_CLEAR || expired)
							used_q[idx_q] <= 1'b0;
						state_q <= (visited_q + CW'(1) == count_q) ? S_OUT : S_RD;
					end else if ((is_write && !occ) || is_match) begin
						if (is_write)
							used_q[idx_q] <= job_q.key_bytes != 4'd0;
						else if (job_q.command == CMD_DELETE)
							used_q[idx_q] <= 1'b0;
						state_q <= S_OUT;
					end else begin
						state_q <= (idx_next == start_q) ? S_OUT : S_RD;
					end
				end
				S_OUT: begin
					out_valid <= 1'b1;
					state_q   <= S_FIN;
				end
				S_FIN: begin
					if (out_ready) begin
						out_valid <= 1'b0;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				job_q            <= job;
				count_q          <= count_eff;
				rem_q            <= '0;
				mbit_q           <= 6'd31;
				idx_q            <= '0;
				visited_q        <= '0;
				removed_q        <= '0;
				status           <= ST_DONE;
				hit              <= 1'b0;
				read_value       <= '0;
				read_value_bytes <= '0;
				if (job.command == CMD_WRITE && job.too_large)
					status <= ST_LARGE;
			end
			S_MOD: begin
				if (rem_sh >= {{(33-CW){1'b0}}, count_q})
					rem_q <= 32'(rem_sh - {{(33-CW){1'b0}}, count_q});
				else
					rem_q <= rem_sh[31:0];
				if (mbit_q == 6'd0 && !is_sweep) begin
					idx_q   <= (rem_sh >= {{(33-CW){1'b0}}, count_q}) ?
						AW'(rem_sh - {{(33-CW){1'b0}}, count_q}) : AW'(rem_sh);
					start_q <= (rem_sh >= {{(33-CW){1'b0}}, count_q}) ?
						AW'(rem_sh - {{(33-CW){1'b0}}, count_q}) : AW'(rem_sh);
				end
				mbit_q <= mbit_q - 6'd1;
			end
			S_CHK: begin
				if (is_sweep) begin
					if (job_q.command == CMD_CLEANUP && expired)
						removed_q <= removed_q + 9'd1;
					idx_q     <= AW'(idx_q + 1'b1);
					visited_q <= visited_q + CW'(1);
				end else if ((is_write && !occ) || is_match) begin
					if (job_q.command == CMD_READ && vl_r != 4'd0) begin
						hit              <= 1'b1;
						read_value       <= val_r & byte_mask(vl_r);
						read_value_bytes <= vl_r;
					end
				end else begin
					idx_q <= idx_next;
					if (idx_next == start_q)
						status <= ST_MISS;
				end
			end
			default: ;
		endcase
	end

	assign removed_count = removed_q;
endmodule

// ----- src/hashed_slot_table_with_expiry_core.sv -----
// ----------------------------------------------------------------------------
// hashed_slot_table_with_expiry_core
// linear probing key/value table with per-entry expiry
// ----------------------------------------------------------------------------
// usage:
//   input channel in_valid/in_ready carries one command beat; output channel
//   out_valid/out_ready returns exactly one result beat per command.
//   registers slot_bytes (addr 0) and slot_count (addr 4) sit on an apb port,
//   to be written only while the block is idle; the block does not enforce it.
// flow:
//   front hashes one key byte per cycle; back reduces the crc by the slot
//   count bit by bit, reads and checks each probed slot (S_RD, S_CHK), then
//   returns the result (S_OUT, S_FIN). cleanup and clear skip the reduction
//   and sweep each configured slot. one item at a time in the back, the
//   front hashes the next while the back works.
// reset:
//   all slots empty at once (occupancy flops), registers to 28 and 256.
// stall:
//   a held result blocks the back; the one-entry hand-off register then
//   holds the front, and in_ready drops.
// ----------------------------------------------------------------------------
module hashed_slot_table_with_expiry_core #(
	parameter int SLOT_DEPTH      = 256,
	parameter int KEY_BYTES_MAX   = 8,
	parameter int VALUE_BYTES_MAX = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  command,
	input  logic [63:0] key,
	input  logic [3:0]  key_bytes,
	input  logic [63:0] value,
	input  logic [3:0]  value_bytes,
	input  logic [63:0] expiry_time,
	input  logic [63:0] current_time,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic        hit,
	output logic [63:0] read_value,
	output logic [3:0]  read_value_bytes,
	output logic [8:0]  removed_count
);
	import hst_pkg::*;

	localparam logic [2:0] ADDR_SLOT_BYTES = 3'd0;
	localparam logic [2:0] ADDR_SLOT_COUNT = 3'd4;

	logic [12:0] slot_bytes_q;
	logic [8:0]  slot_count_q;
	logic        job_valid, job_ready;
	job_t        job;

	// config registers
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_bytes_q <= 13'd28;
			slot_count_q <= 9'd256;
		end else if (psel && penable && pwrite) begin
			if (paddr == ADDR_SLOT_BYTES)
				slot_bytes_q <= pwdata[12:0];
			else if (paddr == ADDR_SLOT_COUNT)
				slot_count_q <= pwdata[8:0];
		end
	end

	always_comb begin
		case (paddr)
			ADDR_SLOT_BYTES: prdata = {19'd0, slot_bytes_q};
			ADDR_SLOT_COUNT: prdata = {23'd0, slot_count_q};
			default:         prdata = '0;
		endcase
	end

	hst_front #(.KEY_BYTES_MAX(KEY_BYTES_MAX), .VALUE_BYTES_MAX(VALUE_BYTES_MAX)) u_front (
		.clk, .arst_n, .in_valid, .in_ready, .command, .key, .key_bytes,
		.value, .value_bytes, .expiry_time, .current_time,
		.slot_bytes(slot_bytes_q), .job_valid, .job_ready, .job
	);

	hst_back #(.SLOT_DEPTH(SLOT_DEPTH)) u_back (
		.clk, .arst_n, .job_valid, .job_ready, .job,
		.slot_count(slot_count_q), .out_valid, .out_ready, .status, .hit,
		.read_value, .read_value_bytes, .removed_count
	);

	// a hit always carries a nonempty value
	a_hit_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit |-> read_value_bytes != 4'd0)
		else $error("hit without value length");

	// a miss or too-large result never reports a hit or a removed count
	a_miss: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_DONE |-> !hit && removed_count == 9'd0)
		else $error("miss with hit or count");

	// held result stays until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status))
		else $error("result dropped");
endmodule
